>>> sv/ors_pkg.sv
// Package for the observation reliability statistics core.
// Holds constants, register codes, pipeline item types and the helper shift and saturation functions.
// No dependencies.
`timescale 1ns / 1ps
package ors_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int QDEPTH = 4;
	localparam logic [62:0] MAX63 = {63{1'b1}};
	localparam logic [63:0] MIN_MAG = 64'h8000_0000_0000_0000;

	localparam logic [1:0] REG_VAR_FACTOR = 2'd0;
	localparam logic [1:0] REG_W_LIMIT = 2'd1;
	localparam logic [1:0] REG_POWER_Q = 2'd2;
	localparam logic [1:0] REG_W_ENABLE = 2'd3;

	localparam logic [35:0] W_LIMIT_RST = 36'd14130442403;
	localparam logic [35:0] POWER_Q_RST = 36'd3607772528;

	localparam logic [1:0] ST_SKIPPED = 2'd0;
	localparam logic [1:0] ST_Z_RANGE = 2'd1;
	localparam logic [1:0] ST_DETERMINED = 2'd2;
	localparam logic [1:0] ST_TOO_LARGE = 2'd3;

	// request as it leaves the front queue
	typedef struct packed {
		logic skip;
		logic neg;
		logic [62:0] apv;
		logic [62:0] rv;
		logic [63:0] mag;
		logic [62:0] limc;
	} item_t;

	typedef struct packed {
		logic skip;
		logic [62:0] apv;
		logic [63:0] mag;
		logic [62:0] limc;
	} sb1_t;

	typedef struct packed {
		logic skip;
		logic neg;
		logic [63:0] root;
		logic [63:0] mag;
		logic [62:0] limc;
	} sb2_t;

	typedef struct packed {
		logic skip;
		logic oor;
		logic [32:0] z33;
		logic [62:0] limc;
		logic [63:0] w;
		logic [63:0] g;
		logic gv;
		logic [63:0] inv;
	} sb4_t;

	typedef struct packed {
		logic skip;
		logic oor;
		logic st3;
		logic [32:0] z33;
		logic [63:0] w;
		logic [63:0] g;
		logic gv;
		logic [62:0] mde;
		logic [62:0] t;
	} res_t;

	function automatic logic [127:0] shl128(input logic [63:0] v, input int unsigned s);
		logic [127:0] x;
		x = {64'd0, v};
		return x << s;
	endfunction

	function automatic logic [62:0] sat63(input logic [127:0] x);
		logic [62:0] r;
		if (x[127:63] != '0) r = MAX63;
		else r = x[62:0];
		return r;
	endfunction

endpackage

>>> sv/ors_front.sv
// Front end: accepts requests, classifies zero-variance cases, queues them.
// Depends on ors_pkg.
`timescale 1ns / 1ps
module ors_front import ors_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [62:0] apriori_variance,
	input  logic [62:0] residual_variance,
	input  logic signed [63:0] residual,
	input  logic pop,
	output logic item_valid,
	output item_t item
);
	localparam int AW = $clog2(QDEPTH);

	item_t mem [QDEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] count_q;
	item_t new_item;
	logic [72:0] lim;
	logic push, do_pop;

	assign in_ready = (count_q != (AW+1)'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign push = in_valid && in_ready;
	assign do_pop = pop && item_valid;
	assign item = mem[rd_ptr_q];

	// 1000 * apv = 1024a - 16a - 8a
	assign lim = {apriori_variance, 10'd0} - {6'd0, apriori_variance, 4'd0}
		- {7'd0, apriori_variance, 3'd0};

	always_comb begin
		new_item.skip = (apriori_variance == '0) || (residual_variance == '0);
		new_item.neg = residual[63];
		new_item.apv = apriori_variance;
		new_item.rv = residual_variance;
		new_item.mag = residual[63] ? (~residual + 64'd1) : residual;
		new_item.limc = (lim[72:63] != '0) ? MAX63 : lim[62:0];
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !do_pop) count_q <= count_q + (AW+1)'(1);
			else if (!push && do_pop) count_q <= count_q - (AW+1)'(1);
		end
	end

endmodule

>>> sv/ors_div.sv
// Pipelined restoring divider, 128-bit dividend over 64-bit divisor, one quotient bit per stage.
// Saturates to all ones on zero divisor or overflow. Depends on ors_pkg.
`timescale 1ns / 1ps
module ors_div import ors_pkg::*; #(
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vi,
	input  logic [63:0] n_hi,
	input  logic [63:0] n_lo,
	input  logic [63:0] d,
	input  logic [SW-1:0] sbi,
	output logic vo,
	output logic [63:0] q,
	output logic [SW-1:0] sbo
);
	localparam int N = 64;

	logic [63:0] rem_s [N];
	logic [63:0] lq_s [N];
	logic [63:0] d_s [N];
	logic sat_s [N];
	logic v_s [N];
	logic [SW-1:0] sb_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [63:0] c_rem, c_lq, c_d;
		logic c_sat, c_v;
		logic [SW-1:0] c_sb;
		logic [64:0] r65, df;
		logic ge;
		if (i == 0) begin : g_in
			assign c_rem = n_hi;
			assign c_lq = n_lo;
			assign c_d = d;
			assign c_sat = (d == '0) || (n_hi >= d);
			assign c_v = vi;
			assign c_sb = sbi;
		end else begin : g_mid
			assign c_rem = rem_s[i-1];
			assign c_lq = lq_s[i-1];
			assign c_d = d_s[i-1];
			assign c_sat = sat_s[i-1];
			assign c_v = v_s[i-1];
			assign c_sb = sb_s[i-1];
		end
		assign r65 = {c_rem, c_lq[63]};
		assign df = r65 - {1'b0, c_d};
		assign ge = (r65 >= {1'b0, c_d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= c_v;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? df[63:0] : r65[63:0];
				lq_s[i] <= {c_lq[62:0], ge};
				d_s[i] <= c_d;
				sat_s[i] <= c_sat;
				sb_s[i] <= c_sb;
			end
		end
	end

	assign vo = v_s[N-1];
	assign q = sat_s[N-1] ? {64{1'b1}} : lq_s[N-1];
	assign sbo = sb_s[N-1];

endmodule

>>> sv/ors_sqrt.sv
// Pipelined integer square root of a 128-bit value, one root bit per stage.
// Depends on ors_pkg.
`timescale 1ns / 1ps
module ors_sqrt import ors_pkg::*; #(
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vi,
	input  logic [127:0] n,
	input  logic [SW-1:0] sbi,
	output logic vo,
	output logic [63:0] r,
	output logic [SW-1:0] sbo
);
	localparam int N = 64;

	logic [65:0] rem_s [N];
	logic [127:0] n_s [N];
	logic [63:0] r_s [N];
	logic v_s [N];
	logic [SW-1:0] sb_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [65:0] c_rem;
		logic [127:0] c_n;
		logic [63:0] c_r;
		logic c_v;
		logic [SW-1:0] c_sb;
		logic [66:0] rr, trial, df;
		logic ge;
		if (i == 0) begin : g_in
			assign c_rem = '0;
			assign c_n = n;
			assign c_r = '0;
			assign c_v = vi;
			assign c_sb = sbi;
		end else begin : g_mid
			assign c_rem = rem_s[i-1];
			assign c_n = n_s[i-1];
			assign c_r = r_s[i-1];
			assign c_v = v_s[i-1];
			assign c_sb = sb_s[i-1];
		end
		// bring down two bits, try (4r + 1)
		assign rr = {c_rem[64:0], c_n[127:126]};
		assign trial = {1'b0, c_r, 2'b01};
		assign ge = (rr >= trial);
		assign df = rr - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= c_v;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? df[65:0] : rr[65:0];
				n_s[i] <= {c_n[125:0], 2'b00};
				r_s[i] <= {c_r[62:0], ge};
				sb_s[i] <= c_sb;
			end
		end
	end

	assign vo = v_s[N-1];
	assign r = r_s[N-1];
	assign sbo = sb_s[N-1];

endmodule

>>> sv/ors_mul.sv
// Two-stage 64x64 unsigned multiplier built from four registered 32x32 partial products.
// Depends on ors_pkg.
`timescale 1ns / 1ps
module ors_mul import ors_pkg::*; #(
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vi,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [SW-1:0] sbi,
	output logic vo,
	output logic [127:0] p,
	output logic [SW-1:0] sbo
);
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic [SW-1:0] sb_s1, sb_s2;
	logic v_s1, v_s2;
	logic [127:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vi;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= a[31:0] * b[31:0];
			pp01_s1 <= a[31:0] * b[63:32];
			pp10_s1 <= a[63:32] * b[31:0];
			pp11_s1 <= a[63:32] * b[63:32];
			sb_s1 <= sbi;
			p_s2 <= {64'd0, pp00_s1} + {32'd0, pp01_s1, 32'd0} + {32'd0, pp10_s1, 32'd0}
				+ {pp11_s1, 64'd0};
			sb_s2 <= sb_s1;
		end
	end

	assign vo = v_s2;
	assign p = p_s2;
	assign sbo = sb_s2;

endmodule

>>> sv/observation_reliability_stats_core.sv
// Observation reliability statistics core (data snooping per observation).
// Throughput: one request per cycle while not stalled; five 64-stage divider/root pipelines set the depth.
// Backpressure stalls the whole back pipeline; a 4-entry front queue keeps taking requests until full.
// Reset (arst_n low) empties the queue and pipeline and loads register defaults.
`timescale 1ns / 1ps
module observation_reliability_stats_core import ors_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [62:0] apriori_variance,
	input  logic [62:0] residual_variance,
	input  logic signed [63:0] residual,
	output logic out_valid,
	input  logic out_ready,
	output logic [32:0] redundancy,
	output logic signed [63:0] normalized_residual,
	output logic [62:0] t_factor,
	output logic [62:0] min_detectable_error,
	output logic [62:0] external_reliability,
	output logic signed [63:0] gross_error_estimate,
	output logic gross_error_valid,
	output logic [1:0] status,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data
);
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
	localparam logic [63:0] EPS_Q = (ONE_Q + 64'd5000000) / 64'd10000000;
	localparam logic [63:0] ZMIN_Q = (ONE_Q + 64'd1000) / 64'd2000;

	// configuration
	logic [62:0] var_factor_q;
	logic [35:0] w_limit_q, power_q_q;
	logic w_enable_q;
	logic [36:0] delta;

	assign cfg_ready = 1'b1;
	assign delta = {1'b0, w_limit_q} + {1'b0, power_q_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_factor_q <= ONE_Q[62:0];
			w_limit_q <= W_LIMIT_RST;
			power_q_q <= POWER_Q_RST;
			w_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VAR_FACTOR: var_factor_q <= cfg_data[62:0];
				REG_W_LIMIT: w_limit_q <= cfg_data[35:0];
				REG_POWER_Q: power_q_q <= cfg_data[35:0];
				REG_W_ENABLE: w_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front
	logic q_valid, en;
	item_t it;

	ors_front u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.apriori_variance, .residual_variance, .residual,
		.pop(en), .item_valid(q_valid), .item(it)
	);

	// segment 1: cof = rv / vf, root = sqrt(rv)
	sb1_t sb1_in, sb1_out;
	logic v1a, v1b, neg1;
	logic [63:0] cof, root1;
	logic [127:0] rv_sh;

	assign rv_sh = shl128({1'b0, it.rv}, FRAC_BITS);
	assign sb1_in = '{skip: it.skip, apv: it.apv, mag: it.mag, limc: it.limc};

	ors_div #(.SW($bits(sb1_t))) u_div_cof (
		.clk, .arst_n, .en, .vi(q_valid), .n_hi(rv_sh[127:64]), .n_lo(rv_sh[63:0]),
		.d({1'b0, var_factor_q}), .sbi(sb1_in), .vo(v1a), .q(cof), .sbo(sb1_out)
	);

	ors_sqrt #(.SW(1)) u_sqrt_root (
		.clk, .arst_n, .en, .vi(q_valid), .n(rv_sh), .sbi(it.neg),
		.vo(v1b), .r(root1), .sbo(neg1)
	);

	// segment 2: z = cof / apv
	sb2_t sb2_in, sb2_out;
	logic v2;
	logic [63:0] z_raw;
	logic [127:0] cof_sh;

	assign cof_sh = shl128(cof, FRAC_BITS);
	assign sb2_in = '{skip: sb1_out.skip, neg: neg1, root: root1, mag: sb1_out.mag,
		limc: sb1_out.limc};

	ors_div #(.SW($bits(sb2_t))) u_div_z (
		.clk, .arst_n, .en, .vi(v1a && v1b), .n_hi(cof_sh[127:64]), .n_lo(cof_sh[63:0]),
		.d({1'b0, sb1_out.apv}), .sbi(sb2_in), .vo(v2), .q(z_raw), .sbo(sb2_out)
	);

	// stage C: clamp just above one, range check
	logic vc_q, skip_c, neg_c, oor_c;
	logic [63:0] z_c, root_c, mag_c, z_adj;
	logic [62:0] limc_c;

	assign z_adj = (z_raw > ONE_Q && z_raw < ONE_Q + EPS_Q) ? ONE_Q : z_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= 1'b0;
		else if (en) vc_q <= v2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skip_c <= sb2_out.skip;
			neg_c <= sb2_out.neg;
			oor_c <= (z_adj > ONE_Q) || (z_adj < ZMIN_Q);
			z_c <= z_adj;
			root_c <= sb2_out.root;
			mag_c <= sb2_out.mag;
			limc_c <= sb2_out.limc;
		end
	end

	// segment 3: w, gross error, 1/z and root/z in parallel
	logic [127:0] mag_sh, one2_sh, root_sh;
	logic v3w, v3g, v3i, v3q, neg3;
	logic [1:0] flags3;
	logic [32:0] z33_3;
	logic [62:0] limc3;
	logic [63:0] wq, gq, invq, qq;

	assign mag_sh = shl128(mag_c, FRAC_BITS);
	assign one2_sh = shl128(64'd1, 2 * FRAC_BITS);
	assign root_sh = shl128(root_c, FRAC_BITS);

	ors_div #(.SW(2)) u_div_w (
		.clk, .arst_n, .en, .vi(vc_q), .n_hi(mag_sh[127:64]), .n_lo(mag_sh[63:0]),
		.d(root_c), .sbi({skip_c, oor_c}), .vo(v3w), .q(wq), .sbo(flags3)
	);

	ors_div #(.SW(33)) u_div_g (
		.clk, .arst_n, .en, .vi(vc_q), .n_hi(mag_sh[127:64]), .n_lo(mag_sh[63:0]),
		.d(z_c), .sbi(z_c[32:0]), .vo(v3g), .q(gq), .sbo(z33_3)
	);

	ors_div #(.SW(1)) u_div_inv (
		.clk, .arst_n, .en, .vi(vc_q), .n_hi(one2_sh[127:64]), .n_lo(one2_sh[63:0]),
		.d(z_c), .sbi(neg_c), .vo(v3i), .q(invq), .sbo(neg3)
	);

	ors_div #(.SW(63)) u_div_q (
		.clk, .arst_n, .en, .vi(vc_q), .n_hi(root_sh[127:64]), .n_lo(root_sh[63:0]),
		.d(z_c), .sbi(limc_c), .vo(v3q), .q(qq), .sbo(limc3)
	);

	// stage D: signs, saturation, flag
	logic vd_q;
	sb4_t d_q;
	logic [62:0] qsat_d;
	logic [63:0] wm, gm, w_n, g_n;
	logic gv_n;

	always_comb begin
		if (neg3) begin
			wm = (wq > MIN_MAG) ? MIN_MAG : wq;
			w_n = ~wm + 64'd1;
			gm = (gq > {1'b0, MAX63}) ? {1'b0, MAX63} : gq;
			g_n = gm;
		end else begin
			wm = (wq > {1'b0, MAX63}) ? {1'b0, MAX63} : wq;
			w_n = wm;
			gm = (gq > MIN_MAG) ? MIN_MAG : gq;
			g_n = ~gm + 64'd1;
		end
		gv_n = w_enable_q && (wm >= {28'd0, w_limit_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_q <= 1'b0;
		else if (en) vd_q <= v3w && v3g && v3i && v3q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.skip <= flags3[1];
			d_q.oor <= flags3[0];
			d_q.z33 <= z33_3;
			d_q.limc <= limc3;
			d_q.w <= w_enable_q ? w_n : 64'd0;
			d_q.g <= gv_n ? g_n : 64'd0;
			d_q.gv <= gv_n;
			d_q.inv <= invq;
			qsat_d <= (qq > {1'b0, MAX63}) ? MAX63 : qq[62:0];
		end
	end

	// segment 4: mde = delta * q
	logic v4;
	sb4_t sb4_out;
	logic [127:0] p_mde;

	ors_mul #(.SW($bits(sb4_t))) u_mul_mde (
		.clk, .arst_n, .en, .vi(vd_q), .a({27'd0, delta}), .b({1'b0, qsat_d}),
		.sbi(d_q), .vo(v4), .p(p_mde), .sbo(sb4_out)
	);

	// stage E: mde saturation, too-large check
	logic ve_q;
	res_t e_q;
	logic [63:0] inv_e;
	logic [62:0] mde_n;

	assign mde_n = sat63(p_mde >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ve_q <= 1'b0;
		else if (en) ve_q <= v4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q.skip <= sb4_out.skip;
			e_q.oor <= sb4_out.oor;
			e_q.st3 <= (mde_n > sb4_out.limc);
			e_q.z33 <= sb4_out.z33;
			e_q.w <= sb4_out.w;
			e_q.g <= sb4_out.g;
			e_q.gv <= sb4_out.gv;
			e_q.mde <= mde_n;
			e_q.t <= '0;
			inv_e <= sb4_out.inv;
		end
	end

	// segment 5: T = sqrt(1/z)
	logic v5;
	res_t sb5_out, sb6_in;
	logic [63:0] t_root;

	ors_sqrt #(.SW($bits(res_t))) u_sqrt_t (
		.clk, .arst_n, .en, .vi(ve_q), .n(shl128(inv_e, FRAC_BITS)), .sbi(e_q),
		.vo(v5), .r(t_root), .sbo(sb5_out)
	);

	always_comb begin
		sb6_in = sb5_out;
		sb6_in.t = (t_root > {1'b0, MAX63}) ? MAX63 : t_root[62:0];
	end

	// segment 6: T squared
	logic v6;
	res_t sb6_out;
	logic [127:0] p_t2;
	logic [62:0] t2;

	ors_mul #(.SW($bits(res_t))) u_mul_t2 (
		.clk, .arst_n, .en, .vi(v5), .a({1'b0, sb6_in.t}), .b({1'b0, sb6_in.t}),
		.sbi(sb6_in), .vo(v6), .p(p_t2), .sbo(sb6_out)
	);

	assign t2 = sat63(p_t2 >> FRAC_BITS);

	// stage G: T^2 - 1 floored at zero
	logic vg_q;
	res_t g_q;
	logic [63:0] t2m_g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vg_q <= 1'b0;
		else if (en) vg_q <= v6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_q <= sb6_out;
			t2m_g <= ({1'b0, t2} > ONE_Q) ? ({1'b0, t2} - ONE_Q) : 64'd0;
		end
	end

	// segment 7/8: ext = delta * sqrt(T^2 - 1)
	logic v7, v8;
	res_t sb7_out, res;
	logic [63:0] s_root;
	logic [127:0] p_ext;

	ors_sqrt #(.SW($bits(res_t))) u_sqrt_ext (
		.clk, .arst_n, .en, .vi(vg_q), .n(shl128(t2m_g, FRAC_BITS)), .sbi(g_q),
		.vo(v7), .r(s_root), .sbo(sb7_out)
	);

	ors_mul #(.SW($bits(res_t))) u_mul_ext (
		.clk, .arst_n, .en, .vi(v7), .a({27'd0, delta}), .b(s_root),
		.sbi(sb7_out), .vo(v8), .p(p_ext), .sbo(res)
	);

	// last multiplier register doubles as the output register
	assign out_valid = v8;
	assign en = !v8 || out_ready;

	always_comb begin
		redundancy = '0;
		normalized_residual = '0;
		t_factor = '0;
		min_detectable_error = '0;
		external_reliability = '0;
		gross_error_estimate = '0;
		gross_error_valid = 1'b0;
		if (res.skip) begin
			status = ST_SKIPPED;
		end else if (res.oor) begin
			status = ST_Z_RANGE;
		end else begin
			status = res.st3 ? ST_TOO_LARGE : ST_DETERMINED;
			redundancy = res.z33;
			normalized_residual = res.w;
			t_factor = res.t;
			min_detectable_error = res.mde;
			external_reliability = sat63(p_ext >> FRAC_BITS);
			gross_error_estimate = res.g;
			gross_error_valid = res.gv;
		end
	end

endmodule

>>> sim/observation_reliability_stats_core_tb.sv
// Self-checking testbench for observation_reliability_stats_core.
// Drives observations and register writes, predicts each result with a bit-exact
// fixed-point model kept here and checks every field in order. Needs ors_pkg.
`timescale 1ns / 1ps
module observation_reliability_stats_core_tb import ors_pkg::*;;

	localparam int FRAC = 32;
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
	localparam logic [63:0] EPS_Q = (ONE_Q + 64'd5000000) / 64'd10000000;
	localparam logic [63:0] ZMIN_Q = (ONE_Q + 64'd1000) / 64'd2000;
	localparam logic [63:0] TOP63 = {1'b0, {63{1'b1}}};
	localparam logic [35:0] WL_MAX = 36'd42949672960;

	typedef struct packed {
		logic [32:0] z;
		logic [63:0] w;
		logic [62:0] t;
		logic [62:0] mde;
		logic [62:0] ext;
		logic [63:0] g;
		logic gv;
		logic [1:0] st;
	} obs_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [62:0] apriori_variance, residual_variance;
	logic signed [63:0] residual;
	logic [32:0] redundancy;
	logic signed [63:0] normalized_residual, gross_error_estimate;
	logic [62:0] t_factor, min_detectable_error, external_reliability;
	logic gross_error_valid;
	logic [1:0] status;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	// register copy
	logic [62:0] m_var_factor;
	logic [35:0] m_w_limit, m_power_q;
	logic m_w_enable;

	obs_result_t expected_results[$];
	int errors = 0;
	bit calm = 0;

	observation_reliability_stats_core uut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	// saturating 128/64 divide, all ones on zero divisor or overflow
	function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
		logic [127:0] q;
		if (d == 0 || n[127:64] >= d) return '1;
		q = n / {64'd0, d};
		return q[63:0];
	endfunction

	function automatic logic [63:0] isqrt(input logic [127:0] n);
		logic [63:0] r, c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] clamp63(input logic [127:0] x);
		if (x > {64'd0, TOP63}) return TOP63;
		return x[63:0];
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		return clamp63(({64'd0, a} * {64'd0, b}) >> FRAC);
	endfunction

	function automatic logic [63:0] fx_sdiv(input logic neg, input logic [63:0] mag,
			input logic [63:0] d);
		logic [63:0] q;
		q = div_sat({64'd0, mag} << FRAC, d);
		if (!neg) return (q > TOP63) ? TOP63 : q;
		if (q > TOP63 + 1) q = TOP63 + 1;
		return -q;
	endfunction

	function automatic obs_result_t reliability_of(input logic [62:0] apv,
			input logic [62:0] rv, input logic [63:0] res);
		obs_result_t r;
		logic neg;
		logic [63:0] mag, cof, z, root, wmag, inv, t, delta, q, mde, t2, ext;
		r = '0;
		neg = res[63];
		mag = neg ? -res : res;
		if (apv == 0 || rv == 0) return r;
		cof = div_sat({65'd0, rv} << FRAC, {1'b0, m_var_factor});
		z = div_sat({64'd0, cof} << FRAC, {1'b0, apv});
		if (z > ONE_Q && z < ONE_Q + EPS_Q) z = ONE_Q;
		if (z > ONE_Q || z < ZMIN_Q) begin
			r.st = ST_Z_RANGE;
			return r;
		end
		r.st = ST_DETERMINED;
		root = isqrt({65'd0, rv} << FRAC);
		if (m_w_enable) begin
			r.w = fx_sdiv(neg, mag, root);
			wmag = r.w[63] ? -r.w : r.w;
			if (wmag >= {28'd0, m_w_limit}) begin
				r.g = fx_sdiv(!neg, mag, z);
				r.gv = 1'b1;
			end
		end
		inv = div_sat(128'd1 << (2 * FRAC), z);
		t = clamp63({64'd0, isqrt({64'd0, inv} << FRAC)});
		delta = {28'd0, m_w_limit} + {28'd0, m_power_q};
		q = div_sat({64'd0, root} << FRAC, z);
		if (q > TOP63) q = TOP63;
		mde = fx_mul(delta, q);
		if ({64'd0, mde} > 128'd1000 * {65'd0, apv}) r.st = ST_TOO_LARGE;
		t2 = fx_mul(t, t);
		t2 = (t2 > ONE_Q) ? t2 - ONE_Q : 0;
		ext = fx_mul(delta, isqrt({64'd0, t2} << FRAC));
		r.z = z[32:0];
		r.t = t[62:0];
		r.mde = mde[62:0];
		r.ext = ext[62:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch: got %h want %h", $realtime, field, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		obs_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding", $realtime);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (redundancy !== e.z)
					report_mismatch("redundancy", 64'(redundancy), 64'(e.z));
				if (normalized_residual !== e.w)
					report_mismatch("normalized_residual", normalized_residual, e.w);
				if (t_factor !== e.t) report_mismatch("t_factor", 64'(t_factor), 64'(e.t));
				if (min_detectable_error !== e.mde)
					report_mismatch("min_detectable_error", 64'(min_detectable_error),
						64'(e.mde));
				if (external_reliability !== e.ext)
					report_mismatch("external_reliability", 64'(external_reliability),
						64'(e.ext));
				if (gross_error_estimate !== e.g)
					report_mismatch("gross_error_estimate", gross_error_estimate, e.g);
				if (gross_error_valid !== e.gv)
					report_mismatch("gross_error_valid", 64'(gross_error_valid), 64'(e.gv));
				if (status !== e.st) report_mismatch("status", 64'(status), 64'(e.st));
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready = 0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_ready = 1;
			end
		end
	end

	task automatic send_obs(input logic [62:0] apv, input logic [62:0] rv,
			input logic [63:0] res);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		apriori_variance = apv;
		residual_variance = rv;
		residual = res;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(reliability_of(apv, rv, res));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		wait (expected_results.size() == 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_VAR_FACTOR: m_var_factor = data[62:0];
			REG_W_LIMIT: m_w_limit = data[35:0];
			REG_POWER_Q: m_power_q = data[35:0];
			REG_W_ENABLE: m_w_enable = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_regs(input logic [62:0] vf, input logic [35:0] wl,
			input logic [35:0] pq, input logic en);
		write_reg(REG_VAR_FACTOR, {1'b0, vf});
		write_reg(REG_W_LIMIT, {28'd0, wl});
		write_reg(REG_POWER_Q, {28'd0, pq});
		write_reg(REG_W_ENABLE, {63'd0, en});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly observations whose redundancy lands in range, some pure noise
	task automatic random_obs(input int n);
		logic [62:0] apv, rv;
		logic [63:0] res;
		logic [127:0] target;
		for (int i = 0; i < n; i++) begin
			apv = 63'(rand64() >> $urandom_range(1, 63));
			if (apv == 0) apv = 1;
			target = ({65'd0, apv} * $urandom_range(33, 65540)) >> 16;
			target = (target * {65'd0, m_var_factor}) >> FRAC;
			if ($urandom_range(0, 15) == 0) target = target + $urandom_range(0, 3) - 1;
			rv = (target > {65'd0, {63{1'b1}}}) ? {63{1'b1}} : target[62:0];
			if (rv == 0) rv = 1;
			res = rand64() >> $urandom_range(0, 63);
			if ($urandom_range(0, 1)) res = -res;
			if ($urandom_range(0, 6) == 0) send_obs(63'(rand64()), 63'(rand64()), rand64());
			else send_obs(apv, rv, res);
		end
	endtask

	task automatic test_directed();
		send_obs(0, 63'd5, 64'd7);
		send_obs(63'd5, 0, 64'd7);
		send_obs(0, 0, 0);
		send_obs({63{1'b1}}, {63{1'b1}}, 64'h7FFF_FFFF_FFFF_FFFF);
		send_obs({63{1'b1}}, {63{1'b1}}, 64'h8000_0000_0000_0000);
		send_obs(63'(ONE_Q), 63'(ONE_Q), 0);
		send_obs(63'(ONE_Q), 63'(ONE_Q + 100), 64'hFFFF_FFFF_0000_0000);
		send_obs(63'(ONE_Q), 63'(ONE_Q + EPS_Q), 64'd12345);
		send_obs(63'(ONE_Q), 63'(ONE_Q + 2 * EPS_Q), 64'd12345);
		send_obs(63'(ONE_Q), 63'(ZMIN_Q), 64'd1);
		send_obs(63'(ONE_Q), 63'(ZMIN_Q - 1), 64'd1);
		send_obs(1, 1, 64'h8000_0000_0000_0000);
		send_obs(1, 1, 64'h7FFF_FFFF_FFFF_FFFF);
		send_obs(63'(ONE_Q), 63'(ONE_Q >> 1), 64'd20 << FRAC);
		send_obs(63'(ONE_Q), 63'(ONE_Q >> 1), -(64'd20 << FRAC));
		send_obs(63'd1000 << FRAC, 63'd999 << FRAC, 64'd1);
		send_obs({63{1'b1}}, 63'd1, 64'd3);
		drain();
	endtask

	task automatic test_w_disabled();
		write_reg(REG_W_ENABLE, 64'd0);
		send_obs(63'(ONE_Q), 63'(ONE_Q >> 1), 64'd20 << FRAC);
		send_obs(1, 1, 64'h8000_0000_0000_0000);
		random_obs(100);
		drain();
		write_reg(REG_W_ENABLE, 64'd1);
	endtask

	task automatic test_register_extremes();
		set_regs(63'd1, 36'd0, 36'd0, 1);
		random_obs(120);
		drain();
		set_regs({63{1'b1}}, WL_MAX, WL_MAX, 1);
		random_obs(120);
		drain();
		set_regs(ONE_Q[62:0], 36'd0, WL_MAX, 1);
		random_obs(120);
		drain();
		set_regs(ONE_Q[62:0] >> 3, WL_MAX, 36'd0, 0);
		random_obs(120);
		drain();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 4; p++) begin
			set_regs(63'(rand64() >> $urandom_range(20, 44)), $urandom_range(0, 1) ?
				{1'b0, 3'($urandom_range(0, 7)), $urandom} : {4'd0, $urandom},
				{4'($urandom_range(0, 9)), $urandom}, $urandom_range(0, 3) != 0);
			random_obs(150);
			drain();
		end
	endtask

	task automatic test_steady_stream();
		set_regs(ONE_Q[62:0], W_LIMIT_RST, POWER_Q_RST, 1);
		calm = 1;
		random_obs(250);
		drain();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		apriori_variance = 0;
		residual_variance = 0;
		residual = 0;
		cfg_valid = 0;
		cfg_index = REG_VAR_FACTOR;
		cfg_data = 0;
		m_var_factor = ONE_Q[62:0];
		m_w_limit = W_LIMIT_RST;
		m_power_q = POWER_Q_RST;
		m_w_enable = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed();
		random_obs(200);
		drain();
		test_w_disabled();
		test_register_extremes();
		test_random_settings();
		test_steady_stream();

		repeat (400) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
